@@ src/poc_pkg.sv @@
// ----------------------------------------------------------------------------
// Order crossover package
// Shared constants, command and status types for the crossover core.
// ----------------------------------------------------------------------------
package poc_pkg;

    localparam int GENE_W      = 6;
    localparam int GENE_VALUES = 1 << GENE_W;

    typedef logic [GENE_W-1:0] t_gene;

    // source of the gene placed in the output register
    typedef enum logic [1:0] {
        SRC_FIRST,
        SRC_SECOND,
        SRC_NONE
    } t_src;

    typedef struct packed {
        logic load;        // transfer of one input item
        logic mark_set;    // mark the segment gene read from the first store
        logic start_emit;  // rewind position and donor cursor
        logic put;         // write one result into the output register
        t_src src;         // where the result gene comes from
        logic skip;        // step the donor cursor past a segment gene
        logic clear_run;   // drop run state after the final result
    } t_poc_cmd;

    typedef struct packed {
        logic seg_done;
        logic pos_in_seg;
        logic donor_end;
        logic donor_marked;
        logic last_pos;
        logic out_free;
    } t_poc_status;

endpackage

@@ src/poc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module poc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/poc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Order crossover controller
// Sequences loading, segment marking and offspring emission.
// ----------------------------------------------------------------------------
module poc_ctrl
    import poc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_last_gene,
    input  t_poc_status i_status,
    output logic        o_in_ready,
    output t_poc_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_MARK_ADDR,
        S_MARK_SET,
        S_EMIT_ADDR,
        S_SEG_DATA,
        S_DONOR_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.src = SRC_NONE;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_gene) begin
                        n_state = S_MARK_ADDR;
                    end
                end
            end
            S_MARK_ADDR: begin
                if (i_status.seg_done) begin
                    o_cmd.start_emit = 1'b1;
                    n_state = S_EMIT_ADDR;
                end else begin
                    n_state = S_MARK_SET;
                end
            end
            S_MARK_SET: begin
                o_cmd.mark_set = 1'b1;
                n_state = S_MARK_ADDR;
            end
            S_EMIT_ADDR: begin
                if (i_status.pos_in_seg) begin
                    n_state = S_SEG_DATA;
                end else if (!i_status.donor_end) begin
                    n_state = S_DONOR_CHECK;
                end else if (i_status.out_free) begin
                    // second parent used up: flag the result
                    o_cmd.put = 1'b1;
                    o_cmd.src = SRC_NONE;
                    o_cmd.clear_run = i_status.last_pos;
                    n_state = i_status.last_pos ? S_LOAD : S_EMIT_ADDR;
                end
            end
            S_SEG_DATA: begin
                if (i_status.out_free) begin
                    o_cmd.put = 1'b1;
                    o_cmd.src = SRC_FIRST;
                    o_cmd.clear_run = i_status.last_pos;
                    n_state = i_status.last_pos ? S_LOAD : S_EMIT_ADDR;
                end
            end
            S_DONOR_CHECK: begin
                if (i_status.donor_marked) begin
                    o_cmd.skip = 1'b1;
                    n_state = S_EMIT_ADDR;
                end else if (i_status.out_free) begin
                    o_cmd.put = 1'b1;
                    o_cmd.src = SRC_SECOND;
                    o_cmd.clear_run = i_status.last_pos;
                    n_state = i_status.last_pos ? S_LOAD : S_EMIT_ADDR;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);

    a_put_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put |-> i_status.out_free)
        else $error("result written while output register occupied");

    a_put_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.put && o_cmd.skip))
        else $error("donor skip and result write in the same cycle");

    a_final_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.put && i_status.last_pos) |=> (r_state == S_LOAD))
        else $error("controller did not return to loading after final result");

endmodule

@@ src/poc_datapath.sv @@
// ----------------------------------------------------------------------------
// Order crossover datapath
// Parent stores, segment marks, counters and the output register.
// ----------------------------------------------------------------------------
module poc_datapath
    import poc_pkg::*;
#(
    parameter int MAX_GENES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_poc_cmd    i_cmd,
    input  t_gene       i_first_parent_gene,
    input  t_gene       i_second_parent_gene,
    input  t_gene       i_cut_start,
    input  t_gene       i_cut_end,
    input  logic        i_last_gene,
    input  logic        i_out_ready,
    output t_poc_status o_status,
    output logic        o_out_valid,
    output t_gene       o_child_position,
    output t_gene       o_child_gene,
    output logic        o_donor_exhausted,
    output logic        o_last_of_run
);

    localparam int AW   = $clog2(MAX_GENES);
    localparam int CW   = $clog2(MAX_GENES + 1);
    localparam int CMPW = (CW > GENE_W) ? CW : GENE_W;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_lo;
    logic [CW-1:0]          r_hi;
    logic [CW-1:0]          r_n;
    logic [CW-1:0]          r_pos;
    logic [CW-1:0]          r_cursor;
    logic [GENE_VALUES-1:0] r_mark;

    logic  r_out_valid;
    t_gene r_out_pos;
    t_gene r_out_gene;
    logic  r_out_exh;
    logic  r_out_last;

    logic          w_store;
    logic [CW-1:0] n_len;
    logic [CW-1:0] n_lo;
    logic [CW-1:0] n_hi;
    logic [CMPW-1:0] w_len_x;
    logic [CMPW-1:0] w_cs_x;
    logic [CMPW-1:0] w_ce_x;
    t_gene         w_first_rd;
    t_gene         w_second_rd;
    t_gene         w_put_gene;

    assign w_store = i_cmd.load && (r_count < CW'(MAX_GENES));

    poc_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_first_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_first_parent_gene),
        .i_rd_addr (r_pos[AW-1:0]),
        .o_rd_data (w_first_rd)
    );

    poc_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_second_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_second_parent_gene),
        .i_rd_addr (r_cursor[AW-1:0]),
        .o_rd_data (w_second_rd)
    );

    // genome length and clamped, ordered cut points for the closing item
    always_comb begin
        n_len   = w_store ? (r_count + CW'(1)) : r_count;
        w_len_x = CMPW'(n_len);
        w_cs_x  = CMPW'(i_cut_start);
        w_ce_x  = CMPW'(i_cut_end);
        if (w_cs_x > w_len_x) begin
            w_cs_x = w_len_x;
        end
        if (w_ce_x > w_len_x) begin
            w_ce_x = w_len_x;
        end
        if (w_cs_x > w_ce_x) begin
            n_lo = w_ce_x[CW-1:0];
            n_hi = w_cs_x[CW-1:0];
        end else begin
            n_lo = w_cs_x[CW-1:0];
            n_hi = w_ce_x[CW-1:0];
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_FIRST:  w_put_gene = w_first_rd;
            SRC_SECOND: w_put_gene = w_second_rd;
            default:    w_put_gene = '0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_run) begin
                r_count <= '0;
                r_mark  <= '0;
            end else begin
                if (w_store) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.mark_set) begin
                    r_mark[w_first_rd] <= 1'b1;
                end
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // run counters and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_last_gene) begin
            r_n   <= n_len;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_pos <= n_lo;
        end else if (i_cmd.start_emit) begin
            r_pos    <= '0;
            r_cursor <= '0;
        end else begin
            if (i_cmd.mark_set || i_cmd.put) begin
                r_pos <= r_pos + CW'(1);
            end
            if (i_cmd.skip || (i_cmd.put && i_cmd.src == SRC_SECOND)) begin
                r_cursor <= r_cursor + CW'(1);
            end
        end
        if (i_cmd.put) begin
            r_out_pos  <= r_pos[GENE_W-1:0];
            r_out_gene <= w_put_gene;
            r_out_exh  <= (i_cmd.src == SRC_NONE);
            r_out_last <= o_status.last_pos;
        end
    end

    always_comb begin
        o_status.seg_done     = (r_pos >= r_hi);
        o_status.pos_in_seg   = (r_pos >= r_lo) && (r_pos < r_hi);
        o_status.donor_end    = (r_cursor >= r_n);
        o_status.donor_marked = r_mark[w_second_rd];
        o_status.last_pos     = ((r_pos + CW'(1)) == r_n);
        o_status.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_child_position  = r_out_pos;
    assign o_child_gene      = r_out_gene;
    assign o_donor_exhausted = r_out_exh;
    assign o_last_of_run     = r_out_last;

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_run |=> (r_count == '0) && (r_mark == '0))
        else $error("run state not cleared after final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_GENES))
        else $error("loaded count beyond store depth");

endmodule

@@ src/permutation_order_crossover_core.sv @@
// ----------------------------------------------------------------------------
// Permutation order crossover core
// Order crossover of two streamed parent permutations into one child.
// ----------------------------------------------------------------------------
// Each input transfer loads one position of both parents; the transfer with
// last_gene set closes the genome (at most MAX_GENES positions) and supplies
// the cut points. The core then marks the segment genes, with an address step
// and a set step per segment position plus a closing address step, and emits
// the child one position per result: an address step and a data step per
// position (only the address step where the second parent is already used
// up), plus an address step and a check step for every second-parent gene
// skipped because it lies in the segment. A result waits while the output
// register is occupied. Each phase steps through a parent store over its
// single registered read port. Input is taken only between runs; a new run
// may load while the final result waits to transfer.
module permutation_order_crossover_core
    import poc_pkg::*;
#(
    parameter int MAX_GENES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_gene i_first_parent_gene,
    input  t_gene i_second_parent_gene,
    input  t_gene i_cut_start,
    input  t_gene i_cut_end,
    input  logic  i_last_gene,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_gene o_child_position,
    output t_gene o_child_gene,
    output logic  o_donor_exhausted,
    output logic  o_last_of_run
);

    t_poc_cmd    w_cmd;
    t_poc_status w_status;

    poc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_gene (i_last_gene),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    poc_datapath #(.MAX_GENES(MAX_GENES)) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_first_parent_gene  (i_first_parent_gene),
        .i_second_parent_gene (i_second_parent_gene),
        .i_cut_start          (i_cut_start),
        .i_cut_end            (i_cut_end),
        .i_last_gene          (i_last_gene),
        .i_out_ready          (i_out_ready),
        .o_status             (w_status),
        .o_out_valid          (o_out_valid),
        .o_child_position     (o_child_position),
        .o_child_gene         (o_child_gene),
        .o_donor_exhausted    (o_donor_exhausted),
        .o_last_of_run        (o_last_of_run)
    );

endmodule

@@ bench/tb_permutation_order_crossover_core.sv @@
// ---------------------------------------------------------------------------
// Order crossover core testbench
// Streams parent genomes into the core, rebuilds each child in a bench-side
// crossover model and compares every child gene field by field, under
// changing amounts of idling on the input and output channels.
// ---------------------------------------------------------------------------
module tb_permutation_order_crossover_core;
    timeunit 1ns;
    timeprecision 1ps;

    import poc_pkg::*;

    localparam int MAX_GENES   = 64;
    localparam int ITEM_TARGET = 95;   // per idling phase
    localparam int TAIL_CYCLES = 500;

    typedef struct {
        t_gene first_gene;
        t_gene second_gene;
        t_gene cut_a;
        t_gene cut_b;
        logic  last;
        bit    hold_off;   // wait for every child gene before sending
    } t_parent_item;

    typedef struct {
        t_gene position;
        t_gene gene;
        logic  exhausted;
        logic  last;
    } t_child_gene;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    t_gene first_gene = '0;
    t_gene second_gene = '0;
    t_gene cut_start = '0;
    t_gene cut_end = '0;
    logic  last_gene = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_gene child_position;
    t_gene child_gene;
    logic  donor_exhausted;
    logic  last_of_run;

    t_parent_item parent_items_q[$];
    t_child_gene  child_genes_q[$];

    // bench copy of the core's run state
    t_gene p1_genes[MAX_GENES];
    t_gene p2_genes[MAX_GENES];
    int    genes_loaded = 0;

    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    items_pushed = 0;
    int    mismatches = 0;
    bit    in_taken = 1'b0;

    permutation_order_crossover_core #(.MAX_GENES(MAX_GENES)) dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_first_parent_gene  (first_gene),
        .i_second_parent_gene (second_gene),
        .i_cut_start          (cut_start),
        .i_cut_end            (cut_end),
        .i_last_gene          (last_gene),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_child_position     (child_position),
        .o_child_gene         (child_gene),
        .o_donor_exhausted    (donor_exhausted),
        .o_last_of_run        (last_of_run)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Store one position; on the closing position build the whole child.
    task automatic crossover_item(input t_gene g1, input t_gene g2, input t_gene cs,
                                  input t_gene ce, input logic fin);
        int          n;
        int          lo;
        int          hi;
        int          t;
        int          donor;
        bit          seg_mark[GENE_VALUES];
        t_child_gene c;
        if (genes_loaded < MAX_GENES) begin
            p1_genes[genes_loaded] = g1;
            p2_genes[genes_loaded] = g2;
            genes_loaded++;
        end
        if (!fin)
            return;
        n  = genes_loaded;
        lo = (int'(cs) > n) ? n : int'(cs);
        hi = (int'(ce) > n) ? n : int'(ce);
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        foreach (seg_mark[i])
            seg_mark[i] = 1'b0;
        for (int p = lo; p < hi; p++)
            seg_mark[p1_genes[p]] = 1'b1;
        donor = 0;
        for (int p = 0; p < n; p++) begin
            c.position  = t_gene'(p);
            c.gene      = '0;
            c.exhausted = 1'b0;
            c.last      = (p == n - 1);
            if (p >= lo && p < hi) begin
                c.gene = p1_genes[p];
            end else begin
                // skip donor genes already placed by the segment
                while (donor < n && seg_mark[p2_genes[donor]])
                    donor++;
                if (donor < n) begin
                    c.gene = p2_genes[donor];
                    donor++;
                end else begin
                    c.exhausted = 1'b1;
                end
            end
            child_genes_q.push_back(c);
        end
        genes_loaded = 0;
    endtask

    function automatic void check_field(string name, logic [5:0] want, logic [5:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endfunction

    // Monitor: record input transfers and check output transfers.
    always @(posedge clk) begin : monitor
        t_child_gene c;
        in_taken = rst_n && in_valid && (in_ready === 1'b1);
        if (in_taken)
            crossover_item(first_gene, second_gene, cut_start, cut_end, last_gene);
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (child_genes_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected child gene, expected none, actual position %0d gene %0d",
                         $realtime, child_position, child_gene);
            end else begin
                c = child_genes_q.pop_front();
                check_field("child_position", c.position, child_position);
                check_field("child_gene", c.gene, child_gene);
                check_field("donor_exhausted", 6'(c.exhausted), 6'(donor_exhausted));
                check_field("last_of_run", 6'(c.last), 6'(last_of_run));
            end
        end
    end

    // Driver: present the next pending item once the previous one is taken.
    always @(negedge clk) begin : driver
        t_parent_item item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (!in_valid || in_taken) begin
                if (parent_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(parent_items_q[0].hold_off && child_genes_q.size() != 0)) begin
                    item = parent_items_q.pop_front();
                    first_gene  <= item.first_gene;
                    second_gene <= item.second_gene;
                    cut_start   <= item.cut_a;
                    cut_end     <= item.cut_b;
                    last_gene   <= item.last;
                    in_valid    <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input int g1, input int g2, input int ca, input int cb,
                             input bit fin, input bit hold);
        t_parent_item item;
        item.first_gene  = t_gene'(g1);
        item.second_gene = t_gene'(g2);
        item.cut_a       = t_gene'(ca);
        item.cut_b       = t_gene'(cb);
        item.last        = fin;
        item.hold_off    = hold;
        parent_items_q.push_back(item);
        items_pushed++;
    endtask

    // Push one genome of n positions: a true permutation pair, a pair with one
    // donor gene broken, or plain noise.
    task automatic push_run(input int n, input int kind, input bit hold);
        int set_a[GENE_VALUES];
        int set_b[GENE_VALUES];
        int m;
        int j;
        int t;
        int ca;
        int cb;
        m = (n < MAX_GENES) ? n : MAX_GENES;
        foreach (set_a[i])
            set_a[i] = i;
        for (int i = GENE_VALUES - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = set_a[i];
            set_a[i] = set_a[j];
            set_a[j] = t;
        end
        set_b = set_a;
        for (int i = m - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = set_b[i];
            set_b[i] = set_b[j];
            set_b[j] = t;
        end
        if (kind == 1) begin
            foreach (set_a[i]) begin
                set_a[i] = $urandom_range(63);
                set_b[i] = $urandom_range(63);
            end
        end else if (kind == 2) begin
            set_b[$urandom_range(m - 1)] = $urandom_range(63);
        end
        if ($urandom_range(3) == 0) begin
            ca = $urandom_range(63);
            cb = $urandom_range(63);
        end else begin
            ca = $urandom_range(m > 63 ? 63 : m);
            cb = $urandom_range(m > 63 ? 63 : m);
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                push_item(i < m ? set_a[i] : $urandom_range(63),
                          i < m ? set_b[i] : $urandom_range(63), ca, cb, 1'b1, hold && i == 0);
            else
                push_item(i < m ? set_a[i] : $urandom_range(63),
                          i < m ? set_b[i] : $urandom_range(63),
                          $urandom_range(63), $urandom_range(63), 1'b0, hold && i == 0);
        end
    endtask

    initial begin : limit
        #10_000_000;
        $display("tb_permutation_order_crossover_core NOT OK");
        $finish;
    end

    initial begin : stimulus
        int r;
        int n;
        int kind;

        // single position, start cut clamped and cuts swapped
        push_item(63, 63, 63, 0, 1'b1, 1'b0);
        // cut points out of order
        push_item(3, 1, 0, 0, 1'b0, 1'b0);
        push_item(0, 2, 0, 0, 1'b0, 1'b0);
        push_item(2, 3, 0, 0, 1'b0, 1'b0);
        push_item(1, 0, 3, 1, 1'b1, 1'b0);
        // empty segment: child is the donor in order; sent after a full drain
        push_item(10, 40, 7, 9, 1'b0, 1'b1);
        push_item(20, 30, 0, 0, 1'b0, 1'b0);
        push_item(30, 20, 0, 0, 1'b0, 1'b0);
        push_item(40, 10, 2, 2, 1'b1, 1'b0);
        // donor runs out: parents are not permutations of each other
        push_item(5, 5, 0, 0, 1'b0, 1'b0);
        push_item(6, 5, 0, 0, 1'b0, 1'b0);
        push_item(7, 5, 0, 1, 1'b1, 1'b0);
        // segment covers the whole genome
        push_item(0, 63, 0, 0, 1'b0, 1'b0);
        push_item(63, 31, 0, 0, 1'b0, 1'b0);
        push_item(31, 0, 0, 3, 1'b1, 1'b0);
        // start cut beyond the genome length
        push_item(1, 5, 0, 0, 1'b0, 1'b0);
        push_item(2, 4, 0, 0, 1'b0, 1'b0);
        push_item(3, 3, 0, 0, 1'b0, 1'b0);
        push_item(4, 2, 0, 0, 1'b0, 1'b0);
        push_item(5, 1, 50, 2, 1'b1, 1'b0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            while (parent_items_q.size() != 0)
                @(negedge clk);
            @(posedge clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // overfill the store once, with the sender holding for a drain
            if (ph == 0)
                push_run(66, 0, 1'b1);
            while (items_pushed < ITEM_TARGET * (ph + 1)) begin
                r = $urandom_range(99);
                if (r < 80)
                    n = $urandom_range(8, 1);
                else if (r < 95)
                    n = $urandom_range(32, 9);
                else
                    n = $urandom_range(70, 60);
                r = $urandom_range(99);
                kind = (r < 75) ? 0 : (r < 88) ? 2 : 1;
                push_run(n, kind, $urandom_range(9) == 0);
            end
        end

        @(negedge clk);
        while (parent_items_q.size() != 0 || in_valid || child_genes_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_permutation_order_crossover_core OK");
        else
            $display("tb_permutation_order_crossover_core NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
src/poc_pkg.sv
src/poc_ram.sv
src/poc_ctrl.sv
src/poc_datapath.sv
src/permutation_order_crossover_core.sv
bench/tb_permutation_order_crossover_core.sv
